// ===== src/ols_pkg.sv =====
package ols_pkg;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_DELETE     = 3'd2,
        OP_FIND       = 3'd3,
        OP_READ_FRONT = 3'd4,
        OP_READ_BACK  = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEARCH,
        S_SHIFT
    } t_state;

    typedef struct packed {
        t_op                operation;
        logic [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [VALUE_W-1:0] read_value;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] entry_count;
    } t_resp;

endpackage

// ===== src/ordered_list_store_unit.sv =====
// channel   direction  handshake            beat
// request   in         start & !busy        i_req  (operation, value)
// result    out        o_valid, one cycle   o_resp (status, read_value, position, entry_count)
//
// push front / push back: result strobes the cycle after the request beat
// read front / read back: one synchronous ram read, then the result is registered in S_READ
// find: one entry compared per cycle from the front
// delete: walk to the match, then one entry moved per cycle through the single ram write port
// synchronous active-low reset empties the list; ram contents stay undefined
// the result is shown for one cycle and is never held back
module ordered_list_store_unit #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ols_pkg::t_req i_req,
    output logic          o_valid,
    output ols_pkg::t_resp o_resp
);

    import ols_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int W  = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [AW-1:0]  r_front, n_front;
    logic [AW-1:0]  r_slot, n_slot;
    logic [AW-1:0]  r_wslot, n_wslot;
    logic [AW-1:0]  r_idx, n_idx;
    t_op            r_op, n_op;
    logic [W-1:0]   r_val, n_val;
    logic           r_valid, n_valid;
    t_resp          r_resp, n_resp;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [W-1:0]   ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [W-1:0]   ram_rdata;

    logic [AW-1:0]  slot_next;
    logic [AW-1:0]  front_prev;
    logic [AW-1:0]  back_free;
    logic [AW-1:0]  back_last;
    logic           is_last;
    logic           is_full;
    logic           is_empty;

    function automatic logic [AW-1:0] wrap(input logic [SW-1:0] sum);
        logic [SW-1:0] d;
        d = SW'(DEPTH);
        return (sum >= d) ? AW'(sum - d) : AW'(sum);
    endfunction

    ols_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign slot_next  = (r_slot == AW'(DEPTH - 1)) ? '0 : r_slot + 1'b1;
    assign front_prev = (r_front == '0) ? AW'(DEPTH - 1) : r_front - 1'b1;
    assign back_free  = wrap(SW'(r_front) + SW'(r_count));
    assign back_last  = wrap(SW'(r_front) + SW'(r_count) - SW'(1));
    assign is_last    = ((CW'(r_idx) + CW'(1)) == r_count);
    assign is_full    = (r_count >= CW'(DEPTH));
    assign is_empty   = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_front <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_front <= n_front;
            r_valid <= n_valid;
        end
        r_slot  <= n_slot;
        r_wslot <= n_wslot;
        r_idx   <= n_idx;
        r_op    <= n_op;
        r_val   <= n_val;
        r_resp  <= n_resp;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_front   = r_front;
        n_slot    = r_slot;
        n_wslot   = r_wslot;
        n_idx     = r_idx;
        n_op      = r_op;
        n_val     = r_val;
        n_valid   = 1'b0;
        n_resp    = r_resp;
        ram_we    = 1'b0;
        ram_waddr = r_wslot;
        ram_wdata = ram_rdata;
        ram_raddr = slot_next;

        case (r_state)
            S_IDLE: begin
                ram_raddr = r_front;
                if (start) begin
                    n_op   = i_req.operation;
                    n_val  = i_req.value[W-1:0];
                    n_resp = '{status: ST_OK, read_value: '0, position: '0,
                               entry_count: COUNT_W'(r_count)};
                    case (i_req.operation)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            n_valid = 1'b1;
                            if (is_full) begin
                                n_resp.status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = i_req.value[W-1:0];
                                if (i_req.operation == OP_PUSH_FRONT) begin
                                    ram_waddr = front_prev;
                                    n_front   = front_prev;
                                end else begin
                                    ram_waddr = back_free;
                                end
                                n_count = r_count + 1'b1;
                                n_resp.entry_count = COUNT_W'(r_count + 1'b1);
                            end
                        end
                        OP_DELETE, OP_FIND: begin
                            if (is_empty) begin
                                n_valid       = 1'b1;
                                n_resp.status = ST_EMPTY;
                            end else begin
                                n_slot  = r_front;
                                n_idx   = '0;
                                n_state = S_SEARCH;
                            end
                        end
                        OP_READ_FRONT, OP_READ_BACK: begin
                            if (is_empty) begin
                                n_valid       = 1'b1;
                                n_resp.status = ST_EMPTY;
                            end else begin
                                if (i_req.operation == OP_READ_BACK) begin
                                    ram_raddr = back_last;
                                end
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_resp.read_value = VALUE_W'(ram_rdata);
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_SEARCH: begin
                // rdata holds the entry at r_idx, the next one is being read
                if (ram_rdata == r_val) begin
                    n_resp.read_value = VALUE_W'(r_val);
                    n_resp.position   = POS_W'(r_idx);
                    if (r_op == OP_FIND || is_last) begin
                        if (r_op == OP_DELETE) begin
                            n_count = r_count - 1'b1;
                            n_resp.entry_count = COUNT_W'(r_count - 1'b1);
                        end
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_wslot = r_slot;
                        n_slot  = slot_next;
                        n_idx   = r_idx + 1'b1;
                        n_state = S_SHIFT;
                    end
                end else if (is_last) begin
                    n_resp.status = ST_NOT_FOUND;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_slot = slot_next;
                    n_idx  = r_idx + 1'b1;
                end
            end
            S_SHIFT: begin
                // move entry r_idx up one place; writes trail the reads
                ram_we = 1'b1;
                if (is_last) begin
                    n_count = r_count - 1'b1;
                    n_resp.entry_count = COUNT_W'(r_count - 1'b1);
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_wslot = r_slot;
                    n_slot  = slot_next;
                    n_idx   = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_resp  = r_resp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while a request is still in work");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !is_full
         && (i_req.operation == OP_PUSH_FRONT || i_req.operation == OP_PUSH_BACK))
        |=> (r_count == $past(r_count) + 1'b1) && o_valid)
        else $error("accepted push did not grow the list");

    a_shift_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (ram_we && r_op == OP_DELETE))
        else $error("entry move outside a delete");

endmodule

// ===== src/ols_ram.sv =====
module ols_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
